>>> rtl/core/dtbpw_pkg.sv
// Shared constants, command/status types and helpers of the depth-tested pixel writer.
package dtbpw_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(STORE_SIZE);

	localparam int CFG_W      = 9;
	localparam int CFG_MAX    = (1 << CFG_W) - 1;
	localparam int WIDTH_CAP  = (MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
	localparam int HEIGHT_CAP = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;
	localparam int IDX_W      = 2 * CFG_W + 1;
	localparam int CFG_IDX_W  = 1;

	localparam int COORD_W    = 16;
	localparam int CH_W       = 8;
	localparam int NUM_CH     = 4;
	localparam int COLOR_W    = CH_W * NUM_CH;
	localparam int DEPTH_W    = 32;
	localparam int SUM_W      = 2 * CH_W;

	localparam int IN_DATA_W  = 2 * COORD_W + COLOR_W + DEPTH_W;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = COLOR_W;
	localparam int STATUS_W   = 2;

	localparam logic [DEPTH_W-1:0] DEPTH_FAR = {1'b0, {(DEPTH_W-1){1'b1}}};
	localparam logic [CH_W-1:0]    CH_MAX    = {CH_W{1'b1}};

	localparam logic [IN_USER_W-1:0] OP_DRAW  = 1'b0;
	localparam logic [IN_USER_W-1:0] OP_CLEAR = 1'b1;

	localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CLIPPED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd256;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd256;

	typedef struct packed {
		logic                load_in;
		logic                load_addr;
		logic                rd_en;
		logic                load_blend;
		logic                clr_wr;
		logic                draw_wr;
		logic                load_out;
		logic [STATUS_W-1:0] out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic clip;
		logic clr_last;
	} dp_sts_t;

	// floor(v / 255) for v up to 255*255, by reciprocal-style add and shift
	function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] v);
		logic [SUM_W:0] v1;
		logic [SUM_W:0] t;
		v1 = {1'b0, v} + (SUM_W+1)'(1);
		t  = v1 + (v1 >> CH_W);
		return t[SUM_W-1:CH_W];
	endfunction

endpackage

>>> rtl/core/dtbpw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtbpw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/dtbpw_dp.sv
// Datapath: frame registers, address and clip logic, stores, blend and result register.
module dtbpw_dp
	import dtbpw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [STATUS_W-1:0]   m_tuser
);

	logic [CFG_W-1:0]     width_q, height_q;
	logic [IN_USER_W-1:0] op_q;
	logic [COORD_W-1:0]   x_q, y_q;
	logic [COLOR_W-1:0]   colour_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [ADDR_W-1:0]    addr_q, cnt_q;
	logic                 clip_q;
	logic [DEPTH_W-1:0]   dnew_q;
	logic [COLOR_W-1:0]   out_colour_q;
	logic [STATUS_W-1:0]  out_status_q;

	logic [CFG_W-1:0]     w_eff, h_eff, row;
	logic [IDX_W-1:0]     idx;
	logic                 clip;
	logic [COLOR_W-1:0]   cur_c, under, over, fin;
	logic [DEPTH_W-1:0]   cur_d;
	logic                 new_near;
	logic [CH_W-1:0]      a;
	logic [ADDR_W-1:0]    waddr;
	logic [COLOR_W-1:0]   wcolour;
	logic [DEPTH_W-1:0]   wdepth;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= s_tuser;
			x_q      <= s_tdata[COORD_W-1:0];
			y_q      <= s_tdata[2*COORD_W-1:COORD_W];
			colour_q <= s_tdata[2*COORD_W+COLOR_W-1:2*COORD_W];
			depth_q  <= s_tdata[IN_DATA_W-1:2*COORD_W+COLOR_W];
		end
	end

	// clamp the frame to the store, then bounds check and flip the row
	always_comb begin
		w_eff = (width_q > CFG_W'(WIDTH_CAP)) ? CFG_W'(WIDTH_CAP) : width_q;
		h_eff = (height_q > CFG_W'(HEIGHT_CAP)) ? CFG_W'(HEIGHT_CAP) : height_q;
		clip  = x_q[COORD_W-1] || y_q[COORD_W-1] ||
		        (x_q >= COORD_W'(w_eff)) || (y_q >= COORD_W'(h_eff));
		row   = h_eff - CFG_W'(1) - y_q[CFG_W-1:0];
		idx   = IDX_W'(x_q[CFG_W-1:0]) + IDX_W'(row) * IDX_W'(w_eff);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_addr) begin
			addr_q <= ADDR_W'(idx);
			clip_q <= clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_in) begin
			cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end
	end

	assign waddr   = cmd.clr_wr ? cnt_q : addr_q;
	assign wcolour = cmd.clr_wr ? colour_q : fin;
	assign wdepth  = cmd.clr_wr ? DEPTH_FAR : dnew_q;

	dtbpw_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_SIZE)) u_colour_ram (
		.clk   (clk),
		.we    (cmd.clr_wr | cmd.draw_wr),
		.waddr (waddr),
		.wdata (wcolour),
		.re    (cmd.rd_en),
		.raddr (addr_q),
		.rdata (cur_c)
	);

	dtbpw_ram #(.WIDTH(DEPTH_W), .DEPTH(STORE_SIZE)) u_depth_ram (
		.clk   (clk),
		.we    (cmd.clr_wr | cmd.draw_wr),
		.waddr (waddr),
		.wdata (wdepth),
		.re    (cmd.rd_en),
		.raddr (addr_q),
		.rdata (cur_d)
	);

	// on equal depths the stored colour stays on top
	always_comb begin
		new_near = $signed(cur_d) > $signed(depth_q);
		under    = new_near ? cur_c : colour_q;
		over     = new_near ? colour_q : cur_c;
		a        = over[COLOR_W-1:COLOR_W-CH_W];
	end

	// an alpha of 255 reduces the blend to a copy of the top colour
	for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
		logic [CH_W-1:0]  u, o;
		logic [SUM_W-1:0] sum_q;
		assign u = under[c*CH_W +: CH_W];
		assign o = over[c*CH_W +: CH_W];

		always_ff @(posedge clk) begin
			if (cmd.load_blend) begin
				sum_q <= SUM_W'(u) * SUM_W'(CH_MAX - a) + SUM_W'(o) * SUM_W'(a);
			end
		end

		assign fin[c*CH_W +: CH_W] = div255(sum_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_blend) begin
			dnew_q <= new_near ? depth_q : cur_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= cmd.out_status;
			case (cmd.out_status)
				ST_WRITTEN: out_colour_q <= fin;
				ST_CLEARED: out_colour_q <= colour_q;
				default:    out_colour_q <= '0;
			endcase
		end
	end

	assign m_tdata      = out_colour_q;
	assign m_tuser      = out_status_q;
	assign sts.is_clear = (op_q == OP_CLEAR);
	assign sts.clip     = clip_q;
	assign sts.clr_last = (cnt_q == ADDR_W'(STORE_SIZE - 1));

endmodule

>>> rtl/core/dtbpw_ctrl.sv
// Controller: item sequencing, clear sweep and output handshake.
module dtbpw_ctrl
	import dtbpw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ADDR  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_BLEND = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]          state_q, state_nxt;
	logic [STATUS_W-1:0] status_q, status_nxt;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_nxt  = state_q;
		status_nxt = status_q;
		cmd        = '0;
		s_tready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.load_addr = 1'b1;
				state_nxt     = sts.is_clear ? S_CLEAR : S_READ;
			end
			S_READ: begin
				if (sts.clip) begin
					status_nxt = ST_CLIPPED;
					state_nxt  = S_EMIT;
				end else begin
					cmd.rd_en = 1'b1;
					state_nxt = S_BLEND;
				end
			end
			S_BLEND: begin
				cmd.load_blend = 1'b1;
				status_nxt     = ST_WRITTEN;
				state_nxt      = S_EMIT;
			end
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					status_nxt = ST_CLEARED;
					state_nxt  = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.out_status = status_q;
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.draw_wr  = (status_q == ST_WRITTEN);
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_WRITTEN;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			status_q <= status_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

>>> rtl/core/depth_tested_blending_pixel_writer.sv
// Top level of the depth-tested, alpha-blending pixel writer.
//
// Input stream (s_*): one transfer is one command. s_tuser selects draw or
// clear; s_tdata carries x, y, the RGBA colour and a signed depth. A draw
// outside the active frame (frame_width by frame_height, clamped to the
// store) is clipped; otherwise the row is flipped, the stored colour and
// depth are read, the nearer colour is blended over the farther one and the
// nearer depth is kept. A clear fills the whole store with its colour and
// the farthest depth; it must precede any draw.
// Output stream (m_*): one transfer per command, with a status in m_tuser
// and the colour now at the pixel (clear colour for a clear, zero if
// clipped) in m_tdata.
// A draw is taken in S_IDLE; S_ADDR registers address and clip, S_READ reads
// the stores, S_BLEND registers the blend, and S_EMIT loads the result and
// writes it back once the output register is free; only then is the next
// command taken. A clip skips S_BLEND; a clear sweeps one entry per cycle.
// Reset: the frame registers return to 256 by 256, the output is emptied;
// store contents are undefined until a clear. While m_tready is low the
// result waits in the output register; one more command is taken and held
// finished behind it, then s_tready stays low.
module depth_tested_blending_pixel_writer
	import dtbpw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // x[15:0], y[31:16], red, green, blue, alpha, depth[95:64]
	input  logic [IN_USER_W-1:0]  s_tuser,   // op: 0 draw, 1 clear
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic [STATUS_W-1:0]   m_tuser,   // status: 0 written, 1 clipped, 2 cleared
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing and output handshake
	dtbpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// addressing, stores, blend and result register
	dtbpw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the depth-tested, alpha-blending pixel writer.
`timescale 1ns / 100ps

module tb_top;
	import dtbpw_pkg::*;

	localparam int QUIET_LIMIT = 300000;   // outlasts a clear, which sweeps all 65536 store entries
	localparam int SETTLE      = 8;        // cycles past the last result
	localparam int IDLE_PCT    = 19;

	// One expected transfer on the result stream
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [COLOR_W-1:0]  colour;
	} pixel_expect_t;

	// Shadow framebuffer: a clear sets the fill colour and forgets every drawn pixel,
	// so only pixels touched since the last clear are kept.
	class pixel_scoreboard;
		logic [CFG_W-1:0]   width_reg;
		logic [CFG_W-1:0]   height_reg;
		logic [COLOR_W-1:0] fill_colour;
		logic [COLOR_W-1:0] painted[int];
		logic signed [DEPTH_W-1:0] nearest[int];
		pixel_expect_t      expected[$];
		int                 errors;

		function new();
			width_reg   = FRAME_WIDTH_RST;
			height_reg  = FRAME_HEIGHT_RST;
			fill_colour = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
			if (index == REG_FRAME_WIDTH)
				width_reg = value;
			else
				height_reg = value;
		endfunction

		function int active_width();
			return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		endfunction

		function int active_height();
			return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Each channel: floor((under*(255-a) + over*a) / 255), a from the top colour
		function logic [COLOR_W-1:0] blend_over(logic [COLOR_W-1:0] under,
				logic [COLOR_W-1:0] over);
			logic [COLOR_W-1:0] mixed;
			int a;
			int ch;
			int u;
			int o;
			a = int'(over[COLOR_W-1 -: CH_W]);
			for (ch = 0; ch < NUM_CH; ch++) begin
				u = int'(under[ch*CH_W +: CH_W]);
				o = int'(over[ch*CH_W +: CH_W]);
				mixed[ch*CH_W +: CH_W] = CH_W'((u * (255 - a) + o * a) / 255);
			end
			return mixed;
		endfunction

		function void note_command(logic [IN_USER_W-1:0] op, logic [COORD_W-1:0] x,
				logic [COORD_W-1:0] y, logic [COLOR_W-1:0] colour, logic [DEPTH_W-1:0] depth);
			pixel_expect_t e;
			int xi;
			int yi;
			int w;
			int h;
			int idx;
			logic [COLOR_W-1:0] cur_c;
			logic [COLOR_W-1:0] under_c;
			logic [COLOR_W-1:0] over_c;
			logic signed [DEPTH_W-1:0] cur_d;
			logic signed [DEPTH_W-1:0] new_d;
			new_d = depth;
			if (op == OP_CLEAR) begin
				fill_colour = colour;
				painted.delete();
				nearest.delete();
				e.status = ST_CLEARED;
				e.colour = colour;
			end else begin
				xi = int'($signed(x));
				yi = int'($signed(y));
				w  = active_width();
				h  = active_height();
				if (xi < 0 || yi < 0 || xi >= w || yi >= h) begin
					e.status = ST_CLIPPED;
					e.colour = '0;
				end else begin
					idx   = xi + (h - 1 - yi) * w;
					cur_c = painted.exists(idx) ? painted[idx] : fill_colour;
					cur_d = nearest.exists(idx) ? nearest[idx] : DEPTH_FAR;
					// on equal depths the stored colour stays on top
					if (cur_d > new_d) begin
						under_c = cur_c;
						over_c  = colour;
					end else begin
						under_c = colour;
						over_c  = cur_c;
					end
					e.colour = (over_c[COLOR_W-1 -: CH_W] == CH_MAX) ? over_c
						: blend_over(under_c, over_c);
					e.status = ST_WRITTEN;
					painted[idx] = e.colour;
					nearest[idx] = (cur_d > new_d) ? new_d : cur_d;
				end
			end
			expected.push_back(e);
		endfunction

		function void check_pixel(logic [STATUS_W-1:0] status, logic [OUT_DATA_W-1:0] data);
			pixel_expect_t e;
			if (expected.size() == 0) begin
				$error("unexpected result: status %0d data %h", status, data);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				errors++;
			end
			if (data[7:0] !== e.colour[7:0]) begin
				$error("out_red: expected %0d, got %0d", e.colour[7:0], data[7:0]);
				errors++;
			end
			if (data[15:8] !== e.colour[15:8]) begin
				$error("out_green: expected %0d, got %0d", e.colour[15:8], data[15:8]);
				errors++;
			end
			if (data[23:16] !== e.colour[23:16]) begin
				$error("out_blue: expected %0d, got %0d", e.colour[23:16], data[23:16]);
				errors++;
			end
			if (data[31:24] !== e.colour[31:24]) begin
				$error("out_alpha: expected %0d, got %0d", e.colour[31:24], data[31:24]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [IN_USER_W-1:0]  s_tuser   = OP_DRAW;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]   m_tuser;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]      cfg_data  = '0;

	pixel_scoreboard sb = new();
	int  items_sent      = 0;
	bit  no_idle_stretch = 1'b0;   // both sides run flat out while this is set

	depth_tested_blending_pixel_writer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one command and hold it until the transfer completes. Valid is left
	// high afterwards so back-to-back commands never drop it within one step.
	task automatic send_command(logic [IN_USER_W-1:0] op, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COLOR_W-1:0] colour, logic [DEPTH_W-1:0] depth);
		no_idle_stretch = (items_sent >= 650 && items_sent < 850);
		while (!no_idle_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {depth, colour, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_command(op, x, y, colour, depth);
		items_sent++;
	endtask

	// Mostly in-frame draws, a good share packed into a 4x4 corner so the same
	// pixels get hit over and over; the rest sit on the frame border or are noise.
	task automatic send_random_draws(int count);
		int n;
		int w;
		int h;
		int pick;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CH_W-1:0]    alpha;
		logic [DEPTH_W-1:0] depth;
		for (n = 0; n < count; n++) begin
			w    = sb.active_width();
			h    = sb.active_height();
			pick = $urandom_range(0, 99);
			if (pick < 15 || w == 0 || h == 0) begin
				x = COORD_W'($urandom);
				y = COORD_W'($urandom);
			end else if (pick < 55) begin
				x = COORD_W'($urandom_range(0, (w < 4) ? w - 1 : 3));
				y = COORD_W'($urandom_range(0, (h < 4) ? h - 1 : 3));
			end else begin
				x = COORD_W'($urandom_range(0, w - 1));
				y = COORD_W'($urandom_range(0, h - 1));
				// push one coordinate just past the border now and then
				if (pick < 65) begin
					case ($urandom_range(0, 3))
						0: x = '1;
						1: x = COORD_W'(w);
						2: y = '1;
						default: y = COORD_W'(h);
					endcase
				end
			end
			pick = $urandom_range(0, 9);
			if (pick < 3)
				alpha = CH_MAX;
			else if (pick == 3)
				alpha = '0;
			else
				alpha = CH_W'($urandom);
			pick = $urandom_range(0, 9);
			if (pick < 4)
				depth = DEPTH_W'($urandom_range(0, 8)) - DEPTH_W'(4);   // invite ties
			else if (pick == 4)
				depth = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			else
				depth = $urandom;
			send_command(OP_DRAW, x, y, {alpha, 24'($urandom)}, depth);
		end
	endtask

	// Drop valid, let every pending result come back, then wait out the SETTLE slack.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both frame registers on consecutive edges; only call when drained.
	task automatic set_frame(logic [CFG_W-1:0] width, logic [CFG_W-1:0] height);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= width;
		@(posedge clk);
		sb.set_reg(REG_FRAME_WIDTH, width);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= height;
		@(posedge clk);
		sb.set_reg(REG_FRAME_HEIGHT, height);
		cfg_we <= 1'b0;
	endtask

	// Result side: check each transfer, stall at random, and once hold off
	// for a long stretch so the block backs up into its input.
	initial begin : result_sink
		int stall_left;
		int results_seen;
		stall_left   = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_pixel(m_tuser, m_tdata);
				results_seen++;
				if (results_seen == 500)
					stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Abort if neither stream moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset frame of 256 by 256. A clear must come before any draw.
		send_command(OP_CLEAR, 16'h1234, 16'h5678, 32'h8020_3040, 32'h0000_0000);
		// Opaque pixel in front of the cleared depth: copied, bottom row flipped to top
		send_command(OP_DRAW, 16'd0, 16'd0, 32'hff11_2233, 32'd100);
		// Farther translucent pixel: stored opaque colour stays
		send_command(OP_DRAW, 16'd0, 16'd0, 32'h80aa_bbcc, 32'd200);
		// Tie on depth: stored colour wins
		send_command(OP_DRAW, 16'd0, 16'd0, 32'h00ff_ffff, 32'd100);
		// Most negative depth always lands in front and blends
		send_command(OP_DRAW, 16'd0, 16'd0, 32'h4d99_0066, 32'h8000_0000);
		// Largest depth ties with the cleared depth
		send_command(OP_DRAW, 16'd255, 16'd255, 32'h0aff_ffff, 32'h7fff_ffff);
		send_command(OP_DRAW, 16'd255, 16'd0, 32'hffff_ffff, 32'hffff_fffb);
		send_command(OP_DRAW, 16'd0, 16'd255, 32'h0000_0000, 32'd0);
		// Transparent pixel in front: the one beneath shows through unchanged
		send_command(OP_DRAW, 16'd1, 16'd1, 32'h00ff_00ff, 32'hffff_0000);
		send_command(OP_DRAW, 16'd1, 16'd1, 32'hff00_ff00, 32'd5);
		// Clipped draws on every side and at the coordinate extremes
		send_command(OP_DRAW, 16'hffff, 16'd0, 32'hffff_ffff, 32'd0);
		send_command(OP_DRAW, 16'd0, 16'hffff, 32'hffff_ffff, 32'd0);
		send_command(OP_DRAW, 16'd256, 16'd0, 32'hffff_ffff, 32'd0);
		send_command(OP_DRAW, 16'd0, 16'd256, 32'hffff_ffff, 32'd0);
		send_command(OP_DRAW, 16'h8000, 16'h8000, 32'hffff_ffff, 32'h8000_0000);
		send_command(OP_DRAW, 16'h7fff, 16'h7fff, 32'hffff_ffff, 32'h7fff_ffff);
		send_command(OP_DRAW, 16'h8000, 16'd5, 32'h1234_5678, 32'd1);
		send_random_draws(300);
		wait_drained();

		// Single pixel frame: every hit lands on the same entry
		set_frame(9'd1, 9'd1);
		send_random_draws(100);
		wait_drained();

		// Zero width, then zero height: everything clips
		set_frame(9'd0, 9'd256);
		send_random_draws(20);
		wait_drained();
		set_frame(9'd256, 9'd0);
		send_random_draws(20);
		wait_drained();

		// Oversized registers clamp to the store size
		set_frame(9'd511, 9'd511);
		send_command(OP_CLEAR, 16'hffff, 16'h0000, 32'hff00_00ff, 32'hffff_ffff);
		send_random_draws(200);
		wait_drained();

		// Odd frame with a clear in the middle of the traffic
		set_frame(9'd17, 9'd9);
		send_random_draws(150);
		send_command(OP_CLEAR, 16'h0000, 16'hffff, {8'($urandom), 24'($urandom)}, $urandom);
		send_random_draws(150);
		wait_drained();

		// Wide and flat, then narrow and tall
		set_frame(9'd300, 9'd2);
		send_random_draws(80);
		wait_drained();
		set_frame(9'd5, 9'd256);
		send_random_draws(80);
		wait_drained();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
